// ===== hdl/rrs_pkg.sv =====
`timescale 1ns / 1ps

package rrs_pkg;

  localparam int ACC_W    = 16;
  localparam int ALT_W    = 24;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 15;
  localparam int MS_W     = 20;
  localparam int HEIGHT_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int CHARGE_PULSE_MS = 1000;

  localparam int IN_ACC_LSB    = 0;
  localparam int IN_ALT_LSB    = 48;
  localparam int IN_TIME_LSB   = 72;
  localparam int IN_STATUS_LSB = 104;
  localparam int IN_TDATA_W    = 112;

  localparam int OUT_STATUS_LSB  = 0;
  localparam int OUT_CHANGED_BIT = 3;
  localparam int OUT_DROGUE_BIT  = 4;
  localparam int OUT_MAIN_BIT    = 5;
  localparam int OUT_MEAN_LSB    = 6;
  localparam int OUT_TDATA_W     = 32;

  typedef enum logic [STATUS_W-1:0] {
    ST_PREPARING = 3'd0,
    ST_READY     = 3'd1,
    ST_ASCENDING = 3'd2,
    ST_DROGUE    = 3'd3,
    ST_MAIN      = 3'd4,
    ST_LANDED    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CH_READY    = 2'd0,
    CH_IGNITING = 2'd1,
    CH_DONE     = 2'd2
  } charge_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIFTOFF_LIMIT   = 3'd0,
    REG_TOUCHDOWN_LIMIT = 3'd1,
    REG_DROGUE_MIN_MS   = 3'd2,
    REG_DROGUE_MAX_MS   = 3'd3,
    REG_APOGEE_DROP     = 3'd4,
    REG_MAIN_MIN_MS     = 3'd5,
    REG_MAIN_MAX_MS     = 3'd6,
    REG_MAIN_HEIGHT     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    status_t           status;
    logic              liftoff_hit;
    logic              touchdown_hit;
  } flight_t;

endpackage

// ===== hdl/rrs_ram.sv =====
`timescale 1ns / 1ps

module rrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/rocket_recovery_sequencer.sv =====
`timescale 1ns / 1ps
// An accepted item passes the pipeline stages and the output register before m_axis offers it.
// Throughput: one item per cycle unless m_axis_tready stalls; window read and sum share
// the first stage; reciprocal multiply, remainder correction and flight decision take one each.
// Reset (synchronous, rst high): registers return to their defaults, pipeline empties,
// window entries read as zero until written (one valid flop per entry, no clearing pass).
module rocket_recovery_sequencer
  import rrs_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // accel_x, accel_y, accel_z, altitude, time_ms, status_in, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status_out, status_changed, drogue_fire, main_fire, avg_altitude, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int SUM_W  = ALT_W + IDX_W;
  localparam int NW     = SUM_W + 1;
  localparam int MW     = NW + 1;
  localparam int SHIFT  = NW + IDX_W;
  localparam int QW     = ALT_W + 1;
  localparam logic [63:0] RECIP_FULL  = (64'd1 << SHIFT) / 64'(WINDOW_DEPTH);
  localparam logic [63:0] OFFSET_FULL = 64'(WINDOW_DEPTH) << ALT_W;
  localparam logic [MW-1:0] RECIP   = RECIP_FULL[MW-1:0];
  localparam logic [NW-1:0] OFFSET  = OFFSET_FULL[NW-1:0];
  localparam logic [NW-1:0] DEPTH_N = NW'(WINDOW_DEPTH);

  function automatic logic over_limit(input logic [3*ACC_W-1:0] acc3,
                                      input logic [LIMIT_W-1:0] lim);
    logic signed [ACC_W:0] a;
    logic signed [ACC_W:0] l;
    logic hit;
    hit = 1'b0;
    l = $signed({2'b00, lim});
    for (int i = 0; i < 3; i++) begin
      a = (ACC_W+1)'($signed(acc3[i*ACC_W +: ACC_W]));
      if (a >= l || a <= -l) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  logic [LIMIT_W-1:0]  liftoff_limit;
  logic [LIMIT_W-1:0]  touchdown_limit;
  logic [MS_W-1:0]     drogue_min_ms;
  logic [MS_W-1:0]     drogue_max_ms;
  logic [HEIGHT_W-1:0] apogee_drop;
  logic [MS_W-1:0]     main_min_ms;
  logic [MS_W-1:0]     main_max_ms;
  logic [HEIGHT_W-1:0] main_height;

  logic                   in_accept;
  logic [IDX_W-1:0]       write_index;
  logic [WINDOW_DEPTH-1:0] filled;
  logic [ALT_W-1:0]       ram_rdata;

  logic                    v1, v2, v3, v4;
  logic                    adv1, adv2, adv3, adv4;
  logic                    free1, free2, free3, free4, free_out;
  flight_t                 f1, f2, f3, f4;
  logic signed [ALT_W-1:0] alt1;
  logic [IDX_W-1:0]        idx1;
  logic                    rvalid1;
  logic signed [ALT_W-1:0] old1;
  logic signed [SUM_W-1:0] window_sum;
  logic signed [SUM_W-1:0] sum_next;
  logic [NW-1:0]           n2, n3;
  logic [NW+MW-1:0]        prod;
  logic [QW-1:0]           q3;
  logic [NW-1:0]           rem;
  logic [QW-1:0]           qfix;
  logic signed [ALT_W-1:0] mean4;

  logic signed [ALT_W-1:0] highest_mean, highest_mean_next;
  logic signed [ALT_W-1:0] launch_altitude, launch_altitude_next;
  logic [TIME_W-1:0]       liftoff_time, liftoff_time_next;
  charge_t                 drogue_state, drogue_state_next;
  charge_t                 main_state, main_state_next;
  logic [TIME_W-1:0]       drogue_fire_time, drogue_fire_time_next;
  logic [TIME_W-1:0]       main_fire_time, main_fire_time_next;
  logic                    drogue_pin, drogue_pin_next;
  logic                    main_pin, main_pin_next;
  status_t                 status_next;
  logic [OUT_TDATA_W-1:0]  out_next;

  logic [TIME_W-1:0]       since;
  logic signed [ALT_W:0]   drop;
  logic signed [ALT_W:0]   height;
  logic                    drogue_due, main_due;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      liftoff_limit   <= LIMIT_W'(24576);
      touchdown_limit <= LIMIT_W'(16384);
      drogue_min_ms   <= MS_W'(8000);
      drogue_max_ms   <= MS_W'(20000);
      apogee_drop     <= HEIGHT_W'(160);
      main_min_ms     <= MS_W'(20000);
      main_max_ms     <= MS_W'(120000);
      main_height     <= HEIGHT_W'(3200);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LIFTOFF_LIMIT:   liftoff_limit   <= cfg_data[LIMIT_W-1:0];
        REG_TOUCHDOWN_LIMIT: touchdown_limit <= cfg_data[LIMIT_W-1:0];
        REG_DROGUE_MIN_MS:   drogue_min_ms   <= cfg_data[MS_W-1:0];
        REG_DROGUE_MAX_MS:   drogue_max_ms   <= cfg_data[MS_W-1:0];
        REG_APOGEE_DROP:     apogee_drop     <= cfg_data[HEIGHT_W-1:0];
        REG_MAIN_MIN_MS:     main_min_ms     <= cfg_data[MS_W-1:0];
        REG_MAIN_MAX_MS:     main_max_ms     <= cfg_data[MS_W-1:0];
        REG_MAIN_HEIGHT:     main_height     <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign free_out = !m_axis_tvalid || m_axis_tready;
  assign adv4  = v4 && free_out;
  assign free4 = !v4 || adv4;
  assign adv3  = v3 && free4;
  assign free3 = !v3 || adv3;
  assign adv2  = v2 && free3;
  assign free2 = !v2 || adv2;
  assign adv1  = v1 && free2;
  assign free1 = !v1 || adv1;

  assign s_axis_tready = free1;
  assign in_accept     = s_axis_tvalid && free1;

  rrs_ram #(
    .WIDTH (ALT_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (adv1),
    .waddr (idx1),
    .wdata (alt1),
    .re    (in_accept),
    .raddr (write_index),
    .rdata (ram_rdata)
  );

  // stage 1: window read returns, update running sum, write back
  assign old1     = rvalid1 ? $signed(ram_rdata) : '0;
  assign sum_next = window_sum + SUM_W'(alt1) - SUM_W'(old1);

  // stage 2: reciprocal multiply on the offset (non-negative) sum
  assign prod = (NW+MW)'(n2) * (NW+MW)'(RECIP);

  // stage 3: correct the quotient by at most one
  assign rem  = n3 - NW'(NW'(q3) * DEPTH_N);
  assign qfix = q3 + QW'(rem >= DEPTH_N);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      write_index <= '0;
      filled      <= '0;
      window_sum  <= '0;
    end else begin
      if (in_accept) begin
        v1          <= 1'b1;
        rvalid1     <= filled[write_index];
        write_index <= (write_index == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : write_index + 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        window_sum   <= sum_next;
        filled[idx1] <= 1'b1;
        v2           <= 1'b1;
      end else if (adv2) begin
        v2 <= 1'b0;
      end
      if (adv2) begin
        v3 <= 1'b1;
      end else if (adv3) begin
        v3 <= 1'b0;
      end
      if (adv3) begin
        v4 <= 1'b1;
      end else if (adv4) begin
        v4 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      idx1 <= write_index;
      alt1 <= $signed(s_axis_tdata[IN_ALT_LSB +: ALT_W]);
      f1.time_ms       <= s_axis_tdata[IN_TIME_LSB +: TIME_W];
      f1.status        <= status_t'(s_axis_tdata[IN_STATUS_LSB +: STATUS_W]);
      f1.liftoff_hit   <= over_limit(s_axis_tdata[IN_ACC_LSB +: 3*ACC_W], liftoff_limit);
      f1.touchdown_hit <= over_limit(s_axis_tdata[IN_ACC_LSB +: 3*ACC_W], touchdown_limit);
    end
    if (adv1) begin
      n2 <= NW'({sum_next[SUM_W-1], sum_next}) + OFFSET;
      f2 <= f1;
    end
    if (adv2) begin
      q3 <= prod[SHIFT +: QW];
      n3 <= n2;
      f3 <= f2;
    end
    if (adv3) begin
      mean4 <= $signed(qfix[ALT_W-1:0]);
      f4    <= f3;
    end
  end

  // stage 4: flight decision
  always_comb begin
    highest_mean_next     = (mean4 > highest_mean) ? mean4 : highest_mean;
    since                 = f4.time_ms - liftoff_time;
    drop                  = (ALT_W+1)'(highest_mean_next) - (ALT_W+1)'(mean4);
    height                = (ALT_W+1)'(mean4) - (ALT_W+1)'(launch_altitude);

    if (since < TIME_W'(drogue_min_ms)) begin
      drogue_due = 1'b0;
    end else if (since >= TIME_W'(drogue_max_ms)) begin
      drogue_due = 1'b1;
    end else begin
      drogue_due = $unsigned(drop) >= (ALT_W+1)'(apogee_drop);
    end

    if (since < TIME_W'(main_min_ms)) begin
      main_due = 1'b0;
    end else if (since > TIME_W'(main_max_ms)) begin
      main_due = 1'b1;
    end else begin
      main_due = height <= $signed((ALT_W+1)'(main_height));
    end

    status_next           = f4.status;
    launch_altitude_next  = launch_altitude;
    liftoff_time_next     = liftoff_time;
    drogue_state_next     = drogue_state;
    main_state_next       = main_state;
    drogue_fire_time_next = drogue_fire_time;
    main_fire_time_next   = main_fire_time;
    drogue_pin_next       = drogue_pin;
    main_pin_next         = main_pin;

    case (f4.status)
      ST_READY: begin
        if (f4.liftoff_hit) begin
          status_next          = ST_ASCENDING;
          launch_altitude_next = mean4;
          liftoff_time_next    = f4.time_ms;
        end
      end
      ST_ASCENDING: begin
        if (drogue_due) begin
          case (drogue_state)
            CH_READY: begin
              drogue_pin_next       = 1'b1;
              drogue_fire_time_next = f4.time_ms;
              drogue_state_next     = CH_IGNITING;
            end
            CH_IGNITING: begin
              if (f4.time_ms - drogue_fire_time >= TIME_W'(CHARGE_PULSE_MS)) begin
                drogue_pin_next   = 1'b0;
                drogue_state_next = CH_DONE;
                status_next       = ST_DROGUE;
              end
            end
            default: begin
              status_next = ST_DROGUE;
            end
          endcase
        end
      end
      ST_DROGUE: begin
        if (main_due) begin
          case (main_state)
            CH_READY: begin
              main_pin_next       = 1'b1;
              main_fire_time_next = f4.time_ms;
              main_state_next     = CH_IGNITING;
            end
            CH_IGNITING: begin
              if (f4.time_ms - main_fire_time >= TIME_W'(CHARGE_PULSE_MS)) begin
                main_pin_next   = 1'b0;
                main_state_next = CH_DONE;
                status_next     = ST_MAIN;
              end
            end
            default: begin
              status_next = ST_MAIN;
            end
          endcase
        end
      end
      ST_MAIN: begin
        if (f4.touchdown_hit) begin
          status_next = ST_LANDED;
        end
      end
      default: ;
    endcase

    out_next = '0;
    out_next[OUT_STATUS_LSB +: STATUS_W] = status_next;
    out_next[OUT_CHANGED_BIT]            = (status_next != f4.status);
    out_next[OUT_DROGUE_BIT]             = drogue_pin_next;
    out_next[OUT_MAIN_BIT]               = main_pin_next;
    out_next[OUT_MEAN_LSB +: ALT_W]      = mean4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_mean     <= '0;
      launch_altitude  <= '0;
      liftoff_time     <= '0;
      drogue_state     <= CH_READY;
      main_state       <= CH_READY;
      drogue_fire_time <= '0;
      main_fire_time   <= '0;
      drogue_pin       <= 1'b0;
      main_pin         <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (adv4) begin
        highest_mean     <= highest_mean_next;
        launch_altitude  <= launch_altitude_next;
        liftoff_time     <= liftoff_time_next;
        drogue_state     <= drogue_state_next;
        main_state       <= main_state_next;
        drogue_fire_time <= drogue_fire_time_next;
        main_fire_time   <= main_fire_time_next;
        drogue_pin       <= drogue_pin_next;
        main_pin         <= main_pin_next;
        m_axis_tvalid    <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      m_axis_tdata <= out_next;
    end
  end

endmodule

// ===== hdl/rrs_checker.sv =====
`timescale 1ns / 1ps

module rrs_checker
  import rrs_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [STATUS_W-1:0] st;
  logic                changed;

  assign st      = m_axis_tdata[OUT_STATUS_LSB +: STATUS_W];
  assign changed = m_axis_tdata[OUT_CHANGED_BIT];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result item offered straight after reset");

  a_change_target: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && changed |->
      st == ST_ASCENDING || st == ST_DROGUE || st == ST_MAIN || st == ST_LANDED)
    else $error("status change to an unreachable status");

  a_drogue_ended: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && changed && st == ST_DROGUE |-> !m_axis_tdata[OUT_DROGUE_BIT])
    else $error("drogue stage entered with drogue pin high");

  a_main_ended: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && changed && st == ST_MAIN |-> !m_axis_tdata[OUT_MAIN_BIT])
    else $error("main stage entered with main pin high");

endmodule

bind rocket_recovery_sequencer rrs_checker u_rrs_checker (.*);

// ===== bench/tb_rocket_recovery_sequencer.sv =====
`timescale 1ns / 1ps

module tb_rocket_recovery_sequencer;
  import rrs_pkg::*;

  localparam int RING_DEPTH = 8;
  localparam int RING_SHIFT = $clog2(RING_DEPTH);
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;
  localparam int MAX_GAP = 13;
  localparam logic [STATUS_W-1:0] ST_SPARE_LOW = 3'd6;
  localparam logic [STATUS_W-1:0] ST_SPARE_HIGH = 3'd7;

  typedef struct {
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
    logic signed [ALT_W-1:0] altitude;
    logic [TIME_W-1:0]       time_ms;
    logic [STATUS_W-1:0]     status;
  } sensor_sample_t;

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic                    changed;
    logic                    drogue;
    logic                    main_pin;
    logic signed [ALT_W-1:0] mean;
  } flight_readout_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [LIMIT_W-1:0]  lim_liftoff = 15'd24576;
  logic [LIMIT_W-1:0]  lim_touchdown = 15'd16384;
  logic [MS_W-1:0]     drogue_min = 20'd8000;
  logic [MS_W-1:0]     drogue_max = 20'd20000;
  logic [HEIGHT_W-1:0] drop_apogee = 16'd160;
  logic [MS_W-1:0]     main_min = 20'd20000;
  logic [MS_W-1:0]     main_max = 20'd120000;
  logic [HEIGHT_W-1:0] height_main = 16'd3200;

  logic signed [ALT_W-1:0] alt_ring [RING_DEPTH] = '{default: '0};
  logic signed [ALT_W+RING_SHIFT-1:0] ring_sum = '0;
  logic [RING_SHIFT-1:0] ring_ptr = '0;
  logic signed [ALT_W-1:0] peak_mean = '0;
  logic signed [ALT_W-1:0] launch_alt = '0;
  logic [TIME_W-1:0] liftoff_ms = '0;
  logic [TIME_W-1:0] drogue_t0 = '0;
  logic [TIME_W-1:0] main_t0 = '0;
  charge_t drogue_charge = CH_READY;
  charge_t main_charge = CH_READY;
  logic drogue_pin_q = 1'b0;
  logic main_pin_q = 1'b0;

  flight_readout_t flight_readouts [$];
  logic [STATUS_W-1:0] flight_status = ST_READY;
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit src_fast = 1'b0;
  bit sink_fast = 1'b0;

  rocket_recovery_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sensor_sample_t make_sample(int ax, int ay, int az, int alt,
                                                 logic [TIME_W-1:0] t,
                                                 logic [STATUS_W-1:0] st);
    sensor_sample_t s;
    s.accel_x = ax[ACC_W-1:0];
    s.accel_y = ay[ACC_W-1:0];
    s.accel_z = az[ACC_W-1:0];
    s.altitude = alt[ALT_W-1:0];
    s.time_ms = t;
    s.status = st;
    return s;
  endfunction

  function automatic bit accel_exceeds(sensor_sample_t s, logic [LIMIT_W-1:0] lim);
    int l;
    int axis [3];
    l = lim;
    axis[0] = s.accel_x;
    axis[1] = s.accel_y;
    axis[2] = s.accel_z;
    foreach (axis[i]) begin
      if (axis[i] >= l || axis[i] <= -l) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic pulse_charge(inout charge_t state, inout logic pin,
                              inout logic [TIME_W-1:0] t0,
                              input logic [TIME_W-1:0] now, output bit complete);
    logic [TIME_W-1:0] held;
    held = now - t0;
    complete = 1'b0;
    case (state)
      CH_READY: begin
        pin = 1'b1;
        t0 = now;
        state = CH_IGNITING;
      end
      CH_IGNITING: begin
        if (held >= TIME_W'(CHARGE_PULSE_MS)) begin
          pin = 1'b0;
          state = CH_DONE;
          complete = 1'b1;
        end
      end
      default: complete = 1'b1;
    endcase
  endtask

  task automatic advance_flight(input sensor_sample_t s, output flight_readout_t r);
    logic signed [ALT_W+RING_SHIFT-1:0] scaled;
    logic signed [ALT_W-1:0] mean;
    logic [TIME_W-1:0] since;
    logic [STATUS_W-1:0] st;
    bit due;
    bit complete;
    ring_sum = ring_sum + s.altitude - alt_ring[ring_ptr];
    alt_ring[ring_ptr] = s.altitude;
    ring_ptr = ring_ptr + 1'b1;
    scaled = ring_sum >>> RING_SHIFT;
    mean = scaled[ALT_W-1:0];
    if (peak_mean < mean) peak_mean = mean;
    st = s.status;
    since = s.time_ms - liftoff_ms;
    case (s.status)
      ST_READY: begin
        if (accel_exceeds(s, lim_liftoff)) begin
          st = ST_ASCENDING;
          launch_alt = mean;
          liftoff_ms = s.time_ms;
        end
      end
      ST_ASCENDING: begin
        if (since < drogue_min) due = 1'b0;
        else if (since >= drogue_max) due = 1'b1;
        else due = (int'(peak_mean) - int'(mean)) >= int'(drop_apogee);
        if (due) begin
          pulse_charge(drogue_charge, drogue_pin_q, drogue_t0, s.time_ms, complete);
          if (complete) st = ST_DROGUE;
        end
      end
      ST_DROGUE: begin
        if (since < main_min) due = 1'b0;
        else if (since > main_max) due = 1'b1;
        else due = (int'(mean) - int'(launch_alt)) <= int'(height_main);
        if (due) begin
          pulse_charge(main_charge, main_pin_q, main_t0, s.time_ms, complete);
          if (complete) st = ST_MAIN;
        end
      end
      ST_MAIN: begin
        if (accel_exceeds(s, lim_touchdown)) st = ST_LANDED;
      end
      default: ;
    endcase
    r.status = st;
    r.changed = (st != s.status);
    r.drogue = drogue_pin_q;
    r.main_pin = main_pin_q;
    r.mean = mean;
  endtask

  task automatic send_sample(input sensor_sample_t s, output logic [STATUS_W-1:0] next_status);
    int gap;
    flight_readout_t r;
    if ($urandom_range(0, 39) == 0) src_fast = !src_fast;
    gap = src_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {s.status, s.time_ms, s.altitude, s.accel_z, s.accel_y, s.accel_x};
    do @(posedge clk); while (!s_axis_tready);
    advance_flight(s, r);
    flight_readouts.push_back(r);
    next_status = r.status;
  endtask

  task automatic drain_readouts();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (flight_readouts.size() != 0);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LIFTOFF_LIMIT:   lim_liftoff = value[LIMIT_W-1:0];
      REG_TOUCHDOWN_LIMIT: lim_touchdown = value[LIMIT_W-1:0];
      REG_DROGUE_MIN_MS:   drogue_min = value[MS_W-1:0];
      REG_DROGUE_MAX_MS:   drogue_max = value[MS_W-1:0];
      REG_APOGEE_DROP:     drop_apogee = value[HEIGHT_W-1:0];
      REG_MAIN_MIN_MS:     main_min = value[MS_W-1:0];
      REG_MAIN_MAX_MS:     main_max = value[MS_W-1:0];
      REG_MAIN_HEIGHT:     height_main = value[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] liftoff, touchdown,
                                input logic [CFG_DATA_W-1:0] d_min, d_max, drop,
                                input logic [CFG_DATA_W-1:0] m_min, m_max, height);
    drain_readouts();
    write_register(REG_LIFTOFF_LIMIT, liftoff);
    write_register(REG_TOUCHDOWN_LIMIT, touchdown);
    write_register(REG_DROGUE_MIN_MS, d_min);
    write_register(REG_DROGUE_MAX_MS, d_max);
    write_register(REG_APOGEE_DROP, drop);
    write_register(REG_MAIN_MIN_MS, m_min);
    write_register(REG_MAIN_MAX_MS, m_max);
    write_register(REG_MAIN_HEIGHT, height);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_accel(logic [LIMIT_W-1:0] lim);
    int l;
    int m;
    l = lim;
    m = $urandom_range(0, l / 2);
    case ($urandom_range(0, 29))
      0, 1: return l;
      2: return -l;
      3: return l - 1;
      4: return 1 - l;
      5: return int'($urandom_range(0, 65535)) - 32768;
      default: return $urandom_range(0, 1) ? m : -m;
    endcase
  endfunction

  task automatic fly_flights(int budget);
    int alt;
    int climb_left;
    int climb_rate;
    int sent;
    int age;
    logic [TIME_W-1:0] clock_ms;
    logic [STATUS_W-1:0] fed;
    logic [STATUS_W-1:0] next_status;
    logic [LIMIT_W-1:0] lim;
    sensor_sample_t s;
    sent = 0;
    while (sent < budget) begin
      flight_status = ST_READY;
      alt = int'($urandom_range(0, 400000)) - 200000;
      clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 60000)
                                             : $urandom;
      climb_left = $urandom_range(4, 40);
      climb_rate = $urandom_range(20, 900);
      age = 0;
      while (sent < budget && age < 160 && flight_status != ST_LANDED) begin
        clock_ms = ($urandom_range(0, 49) == 0) ? $urandom
                                                : clock_ms + $urandom_range(100, 2600);
        if (flight_status == ST_READY) begin
          alt += int'($urandom_range(0, 100)) - 50;
        end else if (climb_left > 0) begin
          alt += climb_rate + int'($urandom_range(0, 200)) - 100;
          climb_left--;
        end else begin
          alt -= climb_rate / 2 + int'($urandom_range(0, 200)) - 100;
        end
        if (alt > 8000000) alt = 8000000;
        if (alt < -8000000) alt = -8000000;
        case (flight_status)
          ST_READY: lim = lim_liftoff;
          ST_MAIN:  lim = lim_touchdown;
          default:  lim = $urandom_range(0, 1) ? lim_liftoff : lim_touchdown;
        endcase
        // occasionally override the held status for one item
        fed = ($urandom_range(0, 24) == 0) ? 3'($urandom_range(0, 7)) : flight_status;
        s = make_sample(pick_accel(lim), pick_accel(lim), pick_accel(lim), alt, clock_ms, fed);
        send_sample(s, next_status);
        if (fed == flight_status) flight_status = next_status;
        sent++;
        age++;
      end
    end
  endtask

  task automatic test_directed_flight();
    logic [TIME_W-1:0] t0;
    logic [STATUS_W-1:0] st;
    t0 = 32'hFFFF_F000;
    send_sample(make_sample(24575, -24575, 24575, 16000, t0 - 32'd10, ST_READY), st);
    send_sample(make_sample(0, -24576, 0, 16000, t0, ST_READY), st);
    send_sample(make_sample(100, 0, 0, 40000, t0 + 32'd7999, ST_ASCENDING), st);
    send_sample(make_sample(100, 0, 0, 60000, t0 + 32'd8000, ST_ASCENDING), st);
    send_sample(make_sample(0, 0, 0, 60000, t0 + 32'd20000, ST_ASCENDING), st);
    send_sample(make_sample(0, 0, 0, 58000, t0 + 32'd20500, ST_PREPARING), st);
    send_sample(make_sample(0, 0, 0, 56000, t0 + 32'd20999, ST_ASCENDING), st);
    send_sample(make_sample(0, 0, 0, 54000, t0 + 32'd21000, ST_ASCENDING), st);
    send_sample(make_sample(0, 0, 0, 50000, t0 + 32'd21500, ST_DROGUE), st);
    send_sample(make_sample(0, 0, 0, 40000, t0 + 32'd120000, ST_DROGUE), st);
    send_sample(make_sample(0, 0, 0, 30000, t0 + 32'd120001, ST_DROGUE), st);
    send_sample(make_sample(0, 0, 0, 20000, t0 + 32'd121001, ST_DROGUE), st);
    send_sample(make_sample(16383, -16383, 0, 16000, t0 + 32'd122000, ST_MAIN), st);
    send_sample(make_sample(0, 0, -16384, 16000, t0 + 32'd123000, ST_MAIN), st);
  endtask

  task automatic test_field_extremes();
    logic [STATUS_W-1:0] st;
    send_sample(make_sample(32767, -32768, 0, 8388607, 32'h0, ST_PREPARING), st);
    send_sample(make_sample(-32768, -32768, -32768, -8388608, 32'hFFFF_FFFF, ST_SPARE_LOW),
                st);
    send_sample(make_sample(32767, 32767, 32767, 8388607, 32'h8000_0000, ST_SPARE_HIGH), st);
    send_sample(make_sample(0, 0, 0, -8388608, 32'h7FFF_FFFF, ST_LANDED), st);
    send_sample(make_sample(-1, 32767, -32768, -1, 32'h1, ST_ASCENDING), st);
    send_sample(make_sample(-32768, 0, 0, 8388607, 32'hFFFF_FFFF, ST_MAIN), st);
  endtask

  task automatic test_reset_settings();
    fly_flights(200);
  endtask

  task automatic test_short_timers();
    apply_settings(CFG_DATA_W'($urandom_range(1000, 30000)),
                   CFG_DATA_W'($urandom_range(1000, 30000)),
                   CFG_DATA_W'($urandom_range(0, 4000)),
                   CFG_DATA_W'($urandom_range(2000, 15000)),
                   CFG_DATA_W'($urandom_range(0, 3000)),
                   CFG_DATA_W'($urandom_range(0, 20000)),
                   CFG_DATA_W'($urandom_range(10000, 60000)),
                   CFG_DATA_W'($urandom_range(0, 40000)));
    fly_flights(250);
  endtask

  task automatic test_zero_settings();
    apply_settings('0, '0, '0, '0, '0, '0, '0, '0);
    fly_flights(100);
  endtask

  task automatic test_full_settings();
    apply_settings('1, '1, '1, '1, '1, '1, '1, '1);
    fly_flights(150);
  endtask

  task automatic test_random_settings();
    apply_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
    fly_flights(150);
  endtask

  task automatic test_random_noise(int budget);
    logic [STATUS_W-1:0] st;
    repeat (budget) begin
      send_sample(make_sample($urandom, $urandom, $urandom, $urandom, $urandom,
                              3'($urandom_range(0, 7))), st);
    end
  endtask

  function automatic void flag_mismatch(string what, logic signed [31:0] want,
                                        logic signed [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endfunction

  task automatic check_readout(input logic [OUT_TDATA_W-1:0] word);
    flight_readout_t got;
    flight_readout_t want;
    got.status = word[OUT_STATUS_LSB +: STATUS_W];
    got.changed = word[OUT_CHANGED_BIT];
    got.drogue = word[OUT_DROGUE_BIT];
    got.main_pin = word[OUT_MAIN_BIT];
    got.mean = word[OUT_MEAN_LSB +: ALT_W];
    if (flight_readouts.size() == 0) begin
      flag_mismatch("item with nothing pending, tdata", 0, word);
    end else begin
      want = flight_readouts.pop_front();
      if (got.status !== want.status) flag_mismatch("status_out", want.status, got.status);
      if (got.changed !== want.changed)
        flag_mismatch("status_changed", want.changed, got.changed);
      if (got.drogue !== want.drogue) flag_mismatch("drogue_fire", want.drogue, got.drogue);
      if (got.main_pin !== want.main_pin)
        flag_mismatch("main_fire", want.main_pin, got.main_pin);
      if (got.mean !== want.mean) flag_mismatch("avg_altitude", want.mean, got.mean);
    end
  endtask

  initial begin : readout_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_fast = !sink_fast;
      stall = sink_fast ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      check_readout(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[rocket_recovery_sequencer] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_flight();
    test_field_extremes();
    test_reset_settings();
    test_short_timers();
    test_zero_settings();
    test_full_settings();
    test_random_settings();
    test_random_settings();
    test_random_noise(100);
    drain_readouts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && flight_readouts.size() == 0) begin
      $display("[rocket_recovery_sequencer] OK");
    end else begin
      $display("[rocket_recovery_sequencer] ERROR");
    end
    $finish;
  end

endmodule
